>>> rtl/core/rev_pkg.sv
// ----------------------------------------------------------------------------
// rev_pkg - recording endpoint VAD shared types and constants
// Item structs, register indexes, sequencer states and default settings.
// ----------------------------------------------------------------------------
package rev_pkg;

  // fixed field widths
  localparam int unsigned SMP_W   = 16;  // PCM sample
  localparam int unsigned LVL_W   = 16;  // mean absolute level / quotient
  localparam int unsigned CNT_W   = 18;  // sample counts
  localparam int unsigned PSUM_W  = 33;  // prefix magnitude sum
  localparam int unsigned CFG_W   = 18;  // widest register
  localparam int unsigned CIDX_W  = 3;

  // parameter defaults
  localparam int unsigned CHUNK_SAMPLES_DEF       = 512;
  localparam int unsigned MAX_CAPTURE_SAMPLES_DEF = 131072;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_VAD_ENABLE     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_THRESH   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SILENCE_THRESH = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SILENCE_NEEDED = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MIN_CAPTURE    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CAPACITY       = 3'd5;

  // register reset values
  localparam logic              RST_VAD_ENABLE     = 1'b1;
  localparam logic [LVL_W-1:0]  RST_START_THRESH   = 16'd1000;
  localparam logic [LVL_W-1:0]  RST_SILENCE_THRESH = 16'd500;
  localparam logic [CNT_W-1:0]  RST_SILENCE_NEEDED = 18'd16000;
  localparam logic [CNT_W-1:0]  RST_MIN_CAPTURE    = 18'd16000;
  localparam logic [CNT_W-1:0]  RST_CAPACITY       = 18'd131072;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    is_prefix;
    logic                    first;
  } vad_in_t;

  typedef struct packed {
    logic             take;
    logic             last;
    logic             status;
    logic             voice_on;
    logic             silence_stop;
    logic [LVL_W-1:0] peak_level;
    logic [CNT_W-1:0] captured_samples;
  } vad_out_t;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_UPD,    // count, accumulate, decide
    S_DIV,    // shared divider running
    S_EVAL,   // use quotient
    S_DONE    // hand result to output register
  } vad_state_t;

endpackage

>>> rtl/core/recording_endpoint_vad_core.sv
// ----------------------------------------------------------------------------
// recording_endpoint_vad_core - energy based end-of-speech detector
// Counts captured samples, tracks chunk mean levels, flags the capture end.
// ----------------------------------------------------------------------------
// One PCM sample item goes in, one result item comes out. An item opening a
// recording carries first=1 and clears the running state. Prefix samples
// (is_prefix=1, before any live sample) are stored and their running mean
// absolute level becomes the peak; they mark voice as started. Live samples are
// grouped into chunks of CHUNK_SAMPLES (the last one cut short when the buffer
// fills); with vad_enable set, each chunk's mean level raises the peak, starts
// voice and counts or clears trailing silence. last is raised on a full buffer,
// on a silence stop, or when a prefix overruns the capacity (status=1). Items
// arriving while no capture runs give take=0, last=0 and hold the other fields.
// Sequence: an item without a division runs S_IDLE, S_UPD, S_DONE; a stored
// prefix sample, or a live sample closing a chunk with VAD enabled, also runs
// S_DIV and S_EVAL, where the one shared 16-step restoring divider forms every
// mean level (one quotient bit per cycle). An item is taken only in S_IDLE,
// once the last result is registered, even if that result waits downstream.
// ----------------------------------------------------------------------------
module recording_endpoint_vad_core #(
  parameter int unsigned CHUNK_SAMPLES       = rev_pkg::CHUNK_SAMPLES_DEF,
  parameter int unsigned MAX_CAPTURE_SAMPLES = rev_pkg::MAX_CAPTURE_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample items
  input  logic                             smp_valid,
  output logic                             smp_stall,
  input  rev_pkg::vad_in_t                 smp_item,
  // result items
  output logic                             res_valid,
  input  logic                             res_stall,
  output rev_pkg::vad_out_t                res_item,
  // register writes
  input  logic                             cfg_we,
  input  logic [rev_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [rev_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned LVL_W  = rev_pkg::LVL_W;
  localparam int unsigned CNT_W  = rev_pkg::CNT_W;
  localparam int unsigned PSUM_W = rev_pkg::PSUM_W;
  // chunk fill must hold CHUNK_SAMPLES itself
  localparam int unsigned FILL_W = $clog2(CHUNK_SAMPLES + 1);
  // magnitude is at most 2^15, so the chunk sum stays below 2^(15+FILL_W)
  localparam int unsigned CSUM_W = LVL_W - 1 + FILL_W;
  // quotient bits: a mean level never exceeds 32768
  localparam int unsigned Q_W    = LVL_W;
  localparam int unsigned QC_W   = $clog2(Q_W);

  localparam logic [FILL_W-1:0] CHUNK_LEN = FILL_W'(CHUNK_SAMPLES);
  localparam logic [CNT_W-1:0]  CAP_MAX   = CNT_W'(MAX_CAPTURE_SAMPLES);

  // registers
  logic                 vad_enable;
  logic [LVL_W-1:0]     start_threshold;
  logic [LVL_W-1:0]     silence_threshold;
  logic [CNT_W-1:0]     silence_needed;
  logic [CNT_W-1:0]     min_capture;
  logic [CNT_W-1:0]     capacity;

  // sequencer and item
  rev_pkg::vad_state_t  state, state_next;
  logic [LVL_W-1:0]     mag, mag_next;
  logic                 pfx, pfx_next;
  logic                 take, take_next;
  logic                 last, last_next;

  // run state
  logic [CNT_W-1:0]     count, count_next;
  logic [FILL_W-1:0]    fill, fill_next;
  logic [CSUM_W-1:0]    csum, csum_next;
  logic [PSUM_W-1:0]    psum, psum_next;
  logic [CNT_W-1:0]     trail, trail_next;
  logic [LVL_W-1:0]     peak, peak_next;
  logic                 active, active_next;
  logic                 live, live_next;
  logic                 voice, voice_next;
  logic                 stopped, stopped_next;
  logic                 error, error_next;

  // divider
  logic [CNT_W-1:0]     rem, rem_next;
  logic [Q_W-1:0]       quot, quot_next;
  logic [Q_W-1:0]       dvd_lo, dvd_lo_next;
  logic [CNT_W-1:0]     divisor, divisor_next;
  logic [QC_W-1:0]      div_cnt, div_cnt_next;
  logic                 div_chunk, div_chunk_next;

  logic                 res_valid_next;
  rev_pkg::vad_out_t    res_item_next;

  // helpers
  logic                 accept;
  logic [LVL_W-1:0]     mag_in;
  logic [CNT_W-1:0]     cap_eff;
  logic [CNT_W-1:0]     count_inc;
  logic [PSUM_W-1:0]    psum_add;
  logic [CSUM_W-1:0]    csum_add;
  logic [FILL_W-1:0]    fill_inc;
  logic                 chunk_end;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic                 eval_start;
  logic [CNT_W-1:0]     trail_eval;
  logic                 voice_eval;

  assign smp_stall = (state != rev_pkg::S_IDLE);
  assign accept    = smp_valid && !smp_stall;

  // |sample|; -32768 maps to 32768, still fits unsigned 16 bits
  assign mag_in = smp_item.sample[LVL_W-1] ? LVL_W'(~smp_item.sample + 1'b1)
                                           : LVL_W'(smp_item.sample);

  // zero capacity acts as one, oversize clamps to the buffer limit
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign count_inc = count + 1'b1;
  assign psum_add  = psum + PSUM_W'(mag);
  assign csum_add  = csum + CSUM_W'(mag);
  assign fill_inc  = fill + 1'b1;
  assign chunk_end = (fill_inc >= CHUNK_LEN) || (count_inc >= cap_eff);

  // one restoring step: bring down next dividend bit, try subtract
  assign trial    = {rem, dvd_lo[Q_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  // chunk level decisions, quotient holds the level
  assign eval_start = !voice && (quot >= start_threshold);
  assign voice_eval = voice || eval_start;
  always_comb begin
    if (eval_start) begin
      trail_eval = '0;
    end else if (voice) begin
      trail_eval = (quot <= silence_threshold) ? CNT_W'(trail + CNT_W'(fill)) : '0;
    end else begin
      trail_eval = trail;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vad_enable        <= rev_pkg::RST_VAD_ENABLE;
      start_threshold   <= rev_pkg::RST_START_THRESH;
      silence_threshold <= rev_pkg::RST_SILENCE_THRESH;
      silence_needed    <= rev_pkg::RST_SILENCE_NEEDED;
      min_capture       <= rev_pkg::RST_MIN_CAPTURE;
      capacity          <= rev_pkg::RST_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rev_pkg::CFG_VAD_ENABLE:     vad_enable        <= cfg_data[0];
        rev_pkg::CFG_START_THRESH:   start_threshold   <= cfg_data[LVL_W-1:0];
        rev_pkg::CFG_SILENCE_THRESH: silence_threshold <= cfg_data[LVL_W-1:0];
        rev_pkg::CFG_SILENCE_NEEDED: silence_needed    <= cfg_data[CNT_W-1:0];
        rev_pkg::CFG_MIN_CAPTURE:    min_capture       <= cfg_data[CNT_W-1:0];
        rev_pkg::CFG_CAPACITY:       capacity          <= cfg_data[CNT_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // sequencer: next state and datapath
  always_comb begin
    state_next     = state;
    mag_next       = mag;
    pfx_next       = pfx;
    take_next      = take;
    last_next      = last;
    count_next     = count;
    fill_next      = fill;
    csum_next      = csum;
    psum_next      = psum;
    trail_next     = trail;
    peak_next      = peak;
    active_next    = active;
    live_next      = live;
    voice_next     = voice;
    stopped_next   = stopped;
    error_next     = error;
    rem_next       = rem;
    quot_next      = quot;
    dvd_lo_next    = dvd_lo;
    divisor_next   = divisor;
    div_cnt_next   = div_cnt;
    div_chunk_next = div_chunk;
    res_item_next  = res_item;
    res_valid_next = res_valid && res_stall;

    unique case (state)
      rev_pkg::S_IDLE: begin
        if (accept) begin
          mag_next  = mag_in;
          pfx_next  = smp_item.is_prefix;
          take_next = 1'b0;
          last_next = 1'b0;
          if (smp_item.first) begin
            // new recording: drop whatever ran before
            count_next   = '0;
            fill_next    = '0;
            csum_next    = '0;
            psum_next    = '0;
            trail_next   = '0;
            peak_next    = '0;
            active_next  = 1'b1;
            live_next    = 1'b0;
            voice_next   = 1'b0;
            stopped_next = 1'b0;
            error_next   = 1'b0;
          end
          state_next = rev_pkg::S_UPD;
        end
      end

      rev_pkg::S_UPD: begin
        state_next = rev_pkg::S_DONE;
        if (active) begin
          if (pfx && !live) begin
            if (count >= cap_eff) begin
              // prefix overran the buffer
              error_next  = 1'b1;
              active_next = 1'b0;
              last_next   = 1'b1;
            end else begin
              take_next      = 1'b1;
              count_next     = count_inc;
              psum_next      = psum_add;
              voice_next     = 1'b1;
              rem_next       = CNT_W'(psum_add[PSUM_W-1:Q_W]);
              dvd_lo_next    = psum_add[Q_W-1:0];
              divisor_next   = count_inc;
              div_cnt_next   = QC_W'(Q_W - 1);
              div_chunk_next = 1'b0;
              state_next     = rev_pkg::S_DIV;
            end
          end else begin
            live_next = 1'b1;
            if (count >= cap_eff) begin
              // buffer filled by the prefix, live sample ends it
              active_next = 1'b0;
              last_next   = 1'b1;
            end else begin
              take_next  = 1'b1;
              count_next = count_inc;
              csum_next  = csum_add;
              fill_next  = fill_inc;
              if (chunk_end && vad_enable) begin
                rem_next       = CNT_W'(PSUM_W'(csum_add) >> Q_W);
                dvd_lo_next    = Q_W'(csum_add);
                divisor_next   = CNT_W'(fill_inc);
                div_cnt_next   = QC_W'(Q_W - 1);
                div_chunk_next = 1'b1;
                state_next     = rev_pkg::S_DIV;
              end else begin
                if (chunk_end) begin
                  fill_next = '0;
                  csum_next = '0;
                end
                if (count_inc >= cap_eff) begin
                  active_next = 1'b0;
                  last_next   = 1'b1;
                end
              end
            end
          end
        end
      end

      rev_pkg::S_DIV: begin
        rem_next    = trial_ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
        quot_next   = {quot[Q_W-2:0], trial_ge};
        dvd_lo_next = {dvd_lo[Q_W-2:0], 1'b0};
        if (div_cnt == '0) begin
          state_next = rev_pkg::S_EVAL;
        end else begin
          div_cnt_next = div_cnt - 1'b1;
        end
      end

      rev_pkg::S_EVAL: begin
        state_next = rev_pkg::S_DONE;
        if (!div_chunk) begin
          peak_next = quot;
        end else begin
          if (quot > peak) begin
            peak_next = quot;
          end
          voice_next = voice_eval;
          trail_next = trail_eval;
          if (voice_eval && (count >= min_capture) && (trail_eval >= silence_needed)) begin
            stopped_next = 1'b1;
            active_next  = 1'b0;
            last_next    = 1'b1;
          end
          fill_next = '0;
          csum_next = '0;
          if (count >= cap_eff) begin
            active_next = 1'b0;
            last_next   = 1'b1;
          end
        end
      end

      rev_pkg::S_DONE: begin
        if (!res_valid || !res_stall) begin
          res_item_next.take             = take;
          res_item_next.last             = last;
          res_item_next.status           = error;
          res_item_next.voice_on         = voice;
          res_item_next.silence_stop     = stopped;
          res_item_next.peak_level       = peak;
          res_item_next.captured_samples = count;
          res_valid_next                 = 1'b1;
          state_next                     = rev_pkg::S_IDLE;
        end
      end

      default: state_next = rev_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rev_pkg::S_IDLE;
      res_valid <= 1'b0;
      count     <= '0;
      fill      <= '0;
      csum      <= '0;
      psum      <= '0;
      trail     <= '0;
      peak      <= '0;
      active    <= 1'b0;
      live      <= 1'b0;
      voice     <= 1'b0;
      stopped   <= 1'b0;
      error     <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      count     <= count_next;
      fill      <= fill_next;
      csum      <= csum_next;
      psum      <= psum_next;
      trail     <= trail_next;
      peak      <= peak_next;
      active    <= active_next;
      live      <= live_next;
      voice     <= voice_next;
      stopped   <= stopped_next;
      error     <= error_next;
      div_cnt   <= div_cnt_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mag       <= mag_next;
    pfx       <= pfx_next;
    take      <= take_next;
    last      <= last_next;
    rem       <= rem_next;
    quot      <= quot_next;
    dvd_lo    <= dvd_lo_next;
    divisor   <= divisor_next;
    div_chunk <= div_chunk_next;
    res_item  <= res_item_next;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - recording endpoint VAD core testbench
// Drives PCM sample items through the valid/stall handshake and compares every
// result item, field by field, with an in-bench predictor of the detector.
// Directed items first, then random recordings under several register settings,
// random idling on both sides, a long receiver hold-off and a silence stop.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SMP_W       = rev_pkg::SMP_W;
  localparam int unsigned LVL_W       = rev_pkg::LVL_W;
  localparam int unsigned CNT_W       = rev_pkg::CNT_W;
  localparam int unsigned PSUM_W      = rev_pkg::PSUM_W;
  localparam int unsigned CFG_W       = rev_pkg::CFG_W;
  localparam int unsigned CIDX_W      = rev_pkg::CIDX_W;
  localparam int unsigned CHUNK       = rev_pkg::CHUNK_SAMPLES_DEF;
  localparam int unsigned MAX_CAP     = rev_pkg::MAX_CAPTURE_SAMPLES_DEF;
  localparam int unsigned HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 40;      // idle tail after the final drain
  localparam int unsigned CYCLE_LIMIT = 400000;

  // sample amplitude classes for stimulus
  typedef enum int {AMP_QUIET, AMP_LOUD, AMP_ANY} amp_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              smp_valid = 1'b0;
  logic              smp_stall;
  rev_pkg::vad_in_t  smp_item  = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  rev_pkg::vad_out_t res_item;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  recording_endpoint_vad_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_item  (smp_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and per-recording running state
  // --------------------------------------------------------------------------
  logic             cfg_vad_en;
  logic [LVL_W-1:0] cfg_start_thr;
  logic [LVL_W-1:0] cfg_quiet_thr;
  logic [CNT_W-1:0] cfg_quiet_need;
  logic [CNT_W-1:0] cfg_min_cap;
  logic [CNT_W-1:0] cfg_capacity;

  logic [CNT_W-1:0]  rec_count;
  logic [9:0]        chunk_fill;
  logic [24:0]       chunk_sum;
  logic [PSUM_W-1:0] prefix_sum;
  logic [CNT_W-1:0]  quiet_run;
  logic [16:0]       peak;        // one bit over the port; the port's 16 bits still hold a level of 32768
  logic rec_active, rec_live, rec_voice, rec_stopped, rec_error;

  rev_pkg::vad_out_t pending_results[$];   // expected results, oldest first
  rev_pkg::vad_out_t seen_exp;

  // bookkeeping
  int n_sent, n_checked, n_mismatch, n_recordings;
  int n_silence_end, n_full_end, n_overrun_end;
  int cycle_count;

  // idling control, read by the sender task and the receiver process
  bit bursty;
  int hold_req, hold_seen, hold_left, stall_left;

  function automatic void clear_recording();
    rec_count   = '0;
    chunk_fill  = '0;
    chunk_sum   = '0;
    prefix_sum  = '0;
    quiet_run   = '0;
    peak        = '0;
    rec_active  = 1'b0;
    rec_live    = 1'b0;
    rec_voice   = 1'b0;
    rec_stopped = 1'b0;
    rec_error   = 1'b0;
  endfunction

  // Works out the result of one accepted item and advances the state.
  function automatic rev_pkg::vad_out_t predict_result(input rev_pkg::vad_in_t it);
    rev_pkg::vad_out_t r;
    logic [15:0]       raw;
    logic [16:0]       mag;
    logic [16:0]       level;
    logic [CNT_W-1:0]  cap;
    raw = it.sample;
    mag = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    // zero capacity acts as one, oversize as the buffer maximum
    if (cfg_capacity == '0) cap = CNT_W'(1);
    else if (cfg_capacity > CNT_W'(MAX_CAP)) cap = CNT_W'(MAX_CAP);
    else cap = cfg_capacity;
    r = '0;

    if (it.first) begin
      clear_recording();
      rec_active = 1'b1;
      n_recordings++;
    end

    if (rec_active) begin
      if (it.is_prefix && !rec_live) begin
        if (rec_count >= cap) begin
          // prefix overruns the buffer
          rec_error  = 1'b1;
          rec_active = 1'b0;
          r.last     = 1'b1;
        end else begin
          r.take     = 1'b1;
          rec_count  = rec_count + 1'b1;
          prefix_sum = prefix_sum + PSUM_W'(mag);
          peak       = 17'(prefix_sum / rec_count);
          rec_voice  = 1'b1;
        end
      end else begin
        rec_live = 1'b1;  // any later prefix mark is ignored
        if (rec_count >= cap) begin
          // buffer already filled by the prefix: no chunk is evaluated
          rec_active = 1'b0;
          r.last     = 1'b1;
        end else begin
          r.take     = 1'b1;
          rec_count  = rec_count + 1'b1;
          chunk_sum  = chunk_sum + 25'(mag);
          chunk_fill = chunk_fill + 1'b1;
          if (chunk_fill >= 10'(CHUNK) || rec_count >= cap) begin
            if (cfg_vad_en) begin
              level = 17'(chunk_sum / chunk_fill);
              if (level > peak) peak = level;
              if (!rec_voice && level >= 17'(cfg_start_thr)) begin
                rec_voice = 1'b1;
                quiet_run = '0;
              end else if (rec_voice) begin
                quiet_run = (level <= 17'(cfg_quiet_thr)) ?
                            quiet_run + CNT_W'(chunk_fill) : '0;
              end
              if (rec_voice && rec_count >= cfg_min_cap && quiet_run >= cfg_quiet_need)
              begin
                rec_stopped = 1'b1;
                rec_active  = 1'b0;
                r.last      = 1'b1;
              end
            end
            chunk_fill = '0;
            chunk_sum  = '0;
          end
          if (rec_count >= cap) begin
            rec_active = 1'b0;
            r.last     = 1'b1;
          end
        end
      end
    end

    if (r.last) begin
      if (rec_error) n_overrun_end++;
      else if (rec_stopped) n_silence_end++;
      else n_full_end++;
    end

    r.status           = rec_error;
    r.voice_on         = rec_voice;
    r.silence_stop     = rec_stopped;
    r.peak_level       = peak[15:0];
    r.captured_samples = rec_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    n_mismatch++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $time, what, got, want, n_checked);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 64'(res_item), 64'(0));
      end else begin
        seen_exp = pending_results.pop_front();
        if (res_item.take !== seen_exp.take)
          report_mismatch("take", 64'(res_item.take), 64'(seen_exp.take));
        if (res_item.last !== seen_exp.last)
          report_mismatch("last", 64'(res_item.last), 64'(seen_exp.last));
        if (res_item.status !== seen_exp.status)
          report_mismatch("status", 64'(res_item.status), 64'(seen_exp.status));
        if (res_item.voice_on !== seen_exp.voice_on)
          report_mismatch("voice_on", 64'(res_item.voice_on), 64'(seen_exp.voice_on));
        if (res_item.silence_stop !== seen_exp.silence_stop)
          report_mismatch("silence_stop", 64'(res_item.silence_stop),
                          64'(seen_exp.silence_stop));
        if (res_item.peak_level !== seen_exp.peak_level)
          report_mismatch("peak_level", 64'(res_item.peak_level),
                          64'(seen_exp.peak_level));
        if (res_item.captured_samples !== seen_exp.captured_samples)
          report_mismatch("captured_samples", 64'(res_item.captured_samples),
                          64'(seen_exp.captured_samples));
        n_checked++;
      end
    end
  end

  // Run limit: far above the slowest legal run (~1000 items, each taking the
  // divider path plus a sender gap and a receiver stall burst, one long hold).
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("** recording_endpoint_vad_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off counted here whenever
  // the test bumps hold_req.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (bursty && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one item (after an optional gap) and waits for it to be accepted.
  // Valid is left high: the next call or drain decides what follows.
  task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic pfx,
                             input logic opens);
    rev_pkg::vad_in_t it;
    int               gap;
    it.sample    = s;
    it.is_prefix = pfx;
    it.first     = opens;
    @(negedge clk);
    if (bursty && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      smp_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_valid <= 1'b1;
    smp_item  <= it;
    @(posedge clk);
    while (smp_stall) @(posedge clk);
    pending_results.push_back(predict_result(it));
    n_sent++;
  endtask

  // Sender pauses until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    smp_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, only ever with the block idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rev_pkg::CFG_VAD_ENABLE:     cfg_vad_en     = val[0];
      rev_pkg::CFG_START_THRESH:   cfg_start_thr  = val[LVL_W-1:0];
      rev_pkg::CFG_SILENCE_THRESH: cfg_quiet_thr  = val[LVL_W-1:0];
      rev_pkg::CFG_SILENCE_NEEDED: cfg_quiet_need = val[CNT_W-1:0];
      rev_pkg::CFG_MIN_CAPTURE:    cfg_min_cap    = val[CNT_W-1:0];
      rev_pkg::CFG_CAPACITY:       cfg_capacity   = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample(input amp_t a);
    logic [15:0] m;
    case (a)
      AMP_QUIET: m = 16'($urandom_range(0, 400));
      AMP_LOUD:  m = 16'($urandom_range(2000, 32767));
      default:   return 16'($urandom);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // One recording: optional prefix, then live samples, the first item opening.
  // With late set, the odd live sample carries a stray prefix mark.
  task automatic play_recording(input int n_pfx, input int n_live, input amp_t amp_p,
                                input amp_t amp_l, input bit late);
    int i;
    for (i = 0; i < n_pfx; i++)
      send_sample(pick_sample(amp_p), 1'b1, i == 0);
    for (i = 0; i < n_live; i++)
      send_sample(pick_sample(amp_l), late && i > 0 && $urandom_range(0, 7) == 0,
                  n_pfx == 0 && i == 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: stray items before any recording, full-scale samples,
  // prefix averaging, a late prefix mark and recordings cut off by a new one.
  task automatic test_idle_and_extremes();
    bursty = 1'b1;
    send_sample(16'sh1234, 1'b0, 1'b0);   // no capture running: ignored
    send_sample(-16'sd1, 1'b1, 1'b0);
    send_sample(16'sd32767, 1'b1, 1'b1);
    send_sample(-16'sd32768, 1'b1, 1'b0);
    send_sample(16'sd0, 1'b0, 1'b0);
    send_sample(-16'sd1, 1'b1, 1'b0);     // prefix mark after live: treated as live
    send_sample(-16'sd32768, 1'b0, 1'b1); // new recording mid-capture
    send_sample(16'sd32767, 1'b0, 1'b0);
    send_sample(16'sd1, 1'b1, 1'b1);
  endtask

  // Buffer limits: prefix that fills then overruns, prefix-filled buffer hit
  // by a live sample, a full-scale short chunk, zero and oversize capacity.
  task automatic test_capacity_limits();
    write_reg(rev_pkg::CFG_CAPACITY, CFG_W'(2));
    send_sample(16'sd500, 1'b1, 1'b1);
    send_sample(-16'sd700, 1'b1, 1'b0);   // count reaches capacity, no end yet
    send_sample(16'sd5, 1'b1, 1'b0);      // overrun: last with status set
    send_sample(16'sd9, 1'b0, 1'b0);      // ignored, status held
    send_sample(16'sd100, 1'b1, 1'b1);
    send_sample(16'sd100, 1'b1, 1'b0);
    send_sample(16'sd3, 1'b0, 1'b0);      // live into a full buffer
    send_sample(-16'sd32768, 1'b0, 1'b1);
    send_sample(-16'sd32768, 1'b0, 1'b0); // level 32768 on the short last chunk
    write_reg(rev_pkg::CFG_CAPACITY, CFG_W'(0));
    send_sample(16'sd2000, 1'b0, 1'b1);
    send_sample(16'sd7, 1'b1, 1'b1);
    send_sample(16'sd7, 1'b1, 1'b0);
    write_reg(rev_pkg::CFG_CAPACITY, CFG_W'(200000));
    send_sample(16'sd12, 1'b0, 1'b1);
    send_sample(-16'sd12, 1'b0, 1'b0);
  endtask

  // Random recordings sized around small capacities, so the last chunk is
  // evaluated at the buffer end, under several register settings.
  task automatic test_random_settings();
    int k, base, cap, n_pfx, n_live;
    for (k = 0; k < 6; k++) begin
      cap = (k == 0) ? 1 : $urandom_range(2, 64);
      write_reg(rev_pkg::CFG_CAPACITY, CFG_W'(cap));
      write_reg(rev_pkg::CFG_VAD_ENABLE, CFG_W'(k != 2));
      case (k)
        0: begin
          write_reg(rev_pkg::CFG_START_THRESH, CFG_W'(0));
          write_reg(rev_pkg::CFG_SILENCE_THRESH, CFG_W'(32768));
          write_reg(rev_pkg::CFG_SILENCE_NEEDED, CFG_W'(0));
          write_reg(rev_pkg::CFG_MIN_CAPTURE, CFG_W'(0));
        end
        1: begin
          write_reg(rev_pkg::CFG_START_THRESH, CFG_W'($urandom_range(0, 6000)));
          write_reg(rev_pkg::CFG_SILENCE_THRESH, CFG_W'($urandom_range(0, 3000)));
          write_reg(rev_pkg::CFG_SILENCE_NEEDED, CFG_W'($urandom_range(0, cap)));
          write_reg(rev_pkg::CFG_MIN_CAPTURE, CFG_W'($urandom_range(0, cap)));
        end
        2, 3: begin
          write_reg(rev_pkg::CFG_START_THRESH, CFG_W'(32768));
          write_reg(rev_pkg::CFG_SILENCE_THRESH, CFG_W'(0));
          write_reg(rev_pkg::CFG_SILENCE_NEEDED, CFG_W'(131072));
          write_reg(rev_pkg::CFG_MIN_CAPTURE, CFG_W'(131072));
        end
        default: begin
          // full-width thresholds, stop criteria kept reachable
          write_reg(rev_pkg::CFG_START_THRESH, CFG_W'($urandom));
          write_reg(rev_pkg::CFG_SILENCE_THRESH, CFG_W'($urandom));
          write_reg(rev_pkg::CFG_SILENCE_NEEDED, CFG_W'($urandom_range(0, cap)));
          write_reg(rev_pkg::CFG_MIN_CAPTURE, CFG_W'($urandom_range(0, cap)));
        end
      endcase
      base = n_sent;
      while (n_sent - base < 50) begin
        bursty = ($urandom_range(0, 3) != 0);
        n_pfx  = $urandom_range(0, 1) ? 0 : $urandom_range(1, cap + 1);
        n_live = $urandom_range(n_pfx == 0, cap + 1);
        play_recording(n_pfx, n_live, amp_t'($urandom_range(0, 2)),
                       amp_t'($urandom_range(0, 2)), 1'b1);
        if ($urandom_range(0, 3) == 0)
          send_sample(pick_sample(AMP_ANY), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  // One long recording: loud prefix, then a full chunk of quiet live samples
  // ends capture on trailing silence before the buffer fills. The receiver
  // holds off at the start of the live part so the block backs up; the last
  // stretch runs with no idling at all.
  task automatic test_silence_stop();
    int i;
    write_reg(rev_pkg::CFG_VAD_ENABLE, CFG_W'(1));
    write_reg(rev_pkg::CFG_START_THRESH, CFG_W'(rev_pkg::RST_START_THRESH));
    write_reg(rev_pkg::CFG_SILENCE_THRESH, CFG_W'(rev_pkg::RST_SILENCE_THRESH));
    write_reg(rev_pkg::CFG_SILENCE_NEEDED, CFG_W'(CHUNK));
    write_reg(rev_pkg::CFG_MIN_CAPTURE, CFG_W'(CHUNK + 8));
    write_reg(rev_pkg::CFG_CAPACITY, CFG_W'(600));
    bursty = 1'b1;
    play_recording(8, 0, AMP_LOUD, AMP_QUIET, 1'b0);
    drain();
    hold_req++;
    for (i = 0; i < CHUNK + 20; i++) begin
      if (i == 260) bursty = 1'b0;
      send_sample(pick_sample(AMP_QUIET), 1'b0, 1'b0);  // tail items are ignored
    end
  endtask

  initial begin
    cfg_vad_en     = rev_pkg::RST_VAD_ENABLE;
    cfg_start_thr  = rev_pkg::RST_START_THRESH;
    cfg_quiet_thr  = rev_pkg::RST_SILENCE_THRESH;
    cfg_quiet_need = rev_pkg::RST_SILENCE_NEEDED;
    cfg_min_cap    = rev_pkg::RST_MIN_CAPTURE;
    cfg_capacity   = rev_pkg::RST_CAPACITY;
    clear_recording();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_and_extremes();
    test_capacity_limits();
    test_random_settings();
    test_silence_stop();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d sample items in %0d recordings, %0d results compared.",
             n_sent, n_recordings, n_checked);
    $display("Captures ended: %0d on trailing silence, %0d on a full buffer, %0d %s",
             n_silence_end, n_full_end, n_overrun_end, "on prefix overrun.");
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("** recording_endpoint_vad_core: PASSED **");
    end else begin
      $display("** recording_endpoint_vad_core: FAILED **");
    end
    $finish;
  end

endmodule
